/* sv/rdpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpp_pkg
// Shared types, constants and helpers of the routing data packet parser.
// ----------------------------------------------------------------------------
package rdpp_pkg;

   localparam int BYTE_W   = 8;
   localparam int NET_W    = 16;
   localparam int DIST_W   = 7;
   localparam int COUNT_W  = 8;
   localparam int POS_W    = 4;
   localparam int PUSH_W   = 2;

   localparam logic [BYTE_W-1:0] DATA_PACKET_TYPE_RESET = 8'h01;
   localparam logic [BYTE_W-1:0] EXPECTED_VERSION_RESET = 8'h82;
   localparam logic [BYTE_W-1:0] ID_LENGTH              = 8'h08;
   localparam int                EXT_BIT                = 7;

   localparam logic [POS_W-1:0] POS_TYPE       = 4'd0;
   localparam logic [POS_W-1:0] POS_NET_HI     = 4'd1;
   localparam logic [POS_W-1:0] POS_NET_LO     = 4'd2;
   localparam logic [POS_W-1:0] POS_ID_LEN     = 4'd3;
   localparam logic [POS_W-1:0] POS_NODE       = 4'd4;
   localparam logic [POS_W-1:0] POS_MIN_HEADER = 4'd5;
   localparam logic [POS_W-1:0] POS_VERSION    = 4'd7;
   localparam logic [POS_W-1:0] POS_DONE       = 4'd8;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_TOO_SHORT   = 3'd1,
      ST_WRONG_TYPE  = 3'd2,
      ST_BAD_ID_LEN  = 3'd3,
      ST_BAD_VERSION = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      TB_NET_HI  = 3'd0,
      TB_NET_LO  = 3'd1,
      TB_DIST    = 3'd2,
      TB_END_HI  = 3'd3,
      TB_END_LO  = 3'd4,
      TB_VERSION = 3'd5
   } tuple_byte_type;

   typedef enum logic {
      KIND_ROUTE   = 1'b0,
      KIND_SUMMARY = 1'b1
   } record_kind_type;

   typedef enum logic {
      CSR_DATA_PACKET_TYPE = 1'b0,
      CSR_EXPECTED_VERSION = 1'b1
   } csr_index_type;

   typedef struct packed {
      record_kind_type     record_kind;
      logic [NET_W-1:0]    start_network;
      logic [NET_W-1:0]    net_end;
      logic [DIST_W-1:0]   hop_distance;
      logic                is_extended;
      logic [NET_W-1:0]    sender_net;
      logic [BYTE_W-1:0]   sender_node;
      status_type          packet_status;
      logic [COUNT_W-1:0]  tuples_seen;
      logic [COUNT_W-1:0]  tuples_dropped;
      logic                last_result;
   } record_type;

   typedef struct packed {
      logic [PUSH_W-1:0] num;
      record_type        first;
      record_type        second;
   } push_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

/* sv/rdpp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpp_if
// Request and response channels of the routing data packet parser.
// ----------------------------------------------------------------------------
interface rdpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rdpp_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_kind;
   logic [15:0] start_network;
   logic [15:0] net_end;
   logic [6:0]  hop_distance;
   logic        is_extended;
   logic [15:0] sender_net;
   logic [7:0]  sender_node;
   logic [2:0]  packet_status;
   logic [7:0]  tuples_seen;
   logic [7:0]  tuples_dropped;
   logic        last_result;

   modport source (
      output valid, output record_kind, output start_network, output net_end,
      output hop_distance, output is_extended, output sender_net,
      output sender_node, output packet_status, output tuples_seen,
      output tuples_dropped, output last_result, input ready
   );
   modport sink (
      input valid, input record_kind, input start_network, input net_end,
      input hop_distance, input is_extended, input sender_net,
      input sender_node, input packet_status, input tuples_seen,
      input tuples_dropped, input last_result, output ready
   );
endinterface

/* sv/rdpp_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpp_parser
// Per-packet header and tuple state; builds up to two records per byte.
// ----------------------------------------------------------------------------
module rdpp_parser
   import rdpp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [BYTE_W-1:0]   data_byte,
   input  logic                last_byte,
   input  logic                csr_write_enable,
   input  csr_index_type       csr_index,
   input  logic [BYTE_W-1:0]   csr_write_data,
   output push_type            push
);

   logic [BYTE_W-1:0]  type_ff, type_in;
   logic [BYTE_W-1:0]  version_ff, version_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   tuple_byte_type     tidx_ff, tidx_in;
   logic [NET_W-1:0]   net_ff, net_in;
   logic [BYTE_W-1:0]  node_ff, node_in;
   logic [NET_W-1:0]   start_ff, start_in;
   logic [BYTE_W-1:0]  dist_ff, dist_in;
   logic [NET_W-1:0]   end_ff, end_in;
   status_type         err_ff, err_in;
   logic [COUNT_W-1:0] emit_ff, emit_in;
   logic [COUNT_W-1:0] drop_ff, drop_in;

   logic               route_valid;
   logic [NET_W-1:0]   r_start;
   logic [NET_W-1:0]   r_end;
   logic [DIST_W-1:0]  r_dist;
   logic               r_ext;
   status_type         sum_status;
   record_type         route_rec;
   record_type         sum_rec;

   always_comb begin
      type_in    = type_ff;
      version_in = version_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DATA_PACKET_TYPE: type_in    = csr_write_data;
            CSR_EXPECTED_VERSION: version_in = csr_write_data;
         endcase
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      tidx_in     = tidx_ff;
      net_in      = net_ff;
      node_in     = node_ff;
      start_in    = start_ff;
      dist_in     = dist_ff;
      end_in      = end_ff;
      err_in      = err_ff;
      emit_in     = emit_ff;
      drop_in     = drop_ff;
      route_valid = 1'b0;
      r_start     = start_ff;
      r_end       = start_ff;
      r_dist      = data_byte[DIST_W-1:0];
      r_ext       = 1'b0;

      if (accept) begin
         case (pos_ff)
            POS_TYPE: begin
               if (data_byte != type_ff && err_ff == ST_OK) err_in = ST_WRONG_TYPE;
            end
            POS_NET_HI: net_in = {data_byte, 8'h00};
            POS_NET_LO: net_in = {net_ff[NET_W-1:BYTE_W], data_byte};
            POS_ID_LEN: begin
               if (data_byte != ID_LENGTH && err_ff == ST_OK) err_in = ST_BAD_ID_LEN;
            end
            POS_NODE: node_in = data_byte;
            default: begin
               if (err_ff == ST_OK) begin
                  case (tidx_ff)
                     TB_NET_HI: begin
                        start_in = {data_byte, 8'h00};
                        tidx_in  = TB_NET_LO;
                     end
                     TB_NET_LO: begin
                        start_in = {start_ff[NET_W-1:BYTE_W], data_byte};
                        tidx_in  = TB_DIST;
                     end
                     TB_DIST: begin
                        dist_in = data_byte;
                        if (pos_ff == POS_VERSION && start_ff == '0) begin
                           if (data_byte == version_ff) tidx_in = TB_NET_HI;
                           else err_in = ST_BAD_VERSION;
                        end else if (!data_byte[EXT_BIT]) begin
                           emit_in     = sat_inc(emit_ff);
                           route_valid = 1'b1;
                           tidx_in     = TB_NET_HI;
                        end else begin
                           tidx_in = TB_END_HI;
                        end
                     end
                     TB_END_HI: begin
                        end_in  = {data_byte, 8'h00};
                        tidx_in = TB_END_LO;
                     end
                     TB_END_LO: begin
                        end_in  = {end_ff[NET_W-1:BYTE_W], data_byte};
                        tidx_in = TB_VERSION;
                     end
                     default: begin
                        if (data_byte == version_ff) begin
                           emit_in     = sat_inc(emit_ff);
                           route_valid = 1'b1;
                           r_end       = end_ff;
                           r_dist      = dist_ff[DIST_W-1:0];
                           r_ext       = 1'b1;
                        end else begin
                           drop_in = sat_inc(drop_ff);
                        end
                        tidx_in = TB_NET_HI;
                     end
                  endcase
               end
            end
         endcase
         if (pos_ff < POS_DONE) pos_in = pos_ff + 1'b1;
      end

      if (pos_in < POS_MIN_HEADER) sum_status = ST_TOO_SHORT;
      else if (err_in == ST_WRONG_TYPE || err_in == ST_BAD_ID_LEN) sum_status = err_in;
      else if (pos_in < POS_DONE) sum_status = ST_TOO_SHORT;
      else sum_status = err_in;

      route_rec.record_kind    = KIND_ROUTE;
      route_rec.start_network  = r_start;
      route_rec.net_end        = r_end;
      route_rec.hop_distance   = r_dist;
      route_rec.is_extended    = r_ext;
      route_rec.sender_net     = net_in;
      route_rec.sender_node    = node_in;
      route_rec.packet_status  = ST_OK;
      route_rec.tuples_seen    = emit_in;
      route_rec.tuples_dropped = drop_in;
      route_rec.last_result    = !last_byte;

      sum_rec.record_kind    = KIND_SUMMARY;
      sum_rec.start_network  = '0;
      sum_rec.net_end        = '0;
      sum_rec.hop_distance   = '0;
      sum_rec.is_extended    = 1'b0;
      sum_rec.sender_net     = net_in;
      sum_rec.sender_node    = node_in;
      sum_rec.packet_status  = sum_status;
      sum_rec.tuples_seen    = emit_in;
      sum_rec.tuples_dropped = drop_in;
      sum_rec.last_result    = 1'b1;

      push.num    = {1'b0, route_valid} + {1'b0, accept && last_byte};
      push.first  = route_valid ? route_rec : sum_rec;
      push.second = sum_rec;

      // drop all packet state after the final byte
      if (accept && last_byte) begin
         pos_in   = '0;
         tidx_in  = TB_NET_HI;
         net_in   = '0;
         node_in  = '0;
         start_in = '0;
         dist_in  = '0;
         end_in   = '0;
         err_in   = ST_OK;
         emit_in  = '0;
         drop_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff    <= DATA_PACKET_TYPE_RESET;
         version_ff <= EXPECTED_VERSION_RESET;
         pos_ff     <= '0;
         tidx_ff    <= TB_NET_HI;
         net_ff     <= '0;
         node_ff    <= '0;
         start_ff   <= '0;
         dist_ff    <= '0;
         end_ff     <= '0;
         err_ff     <= ST_OK;
         emit_ff    <= '0;
         drop_ff    <= '0;
      end else begin
         type_ff    <= type_in;
         version_ff <= version_in;
         pos_ff     <= pos_in;
         tidx_ff    <= tidx_in;
         net_ff     <= net_in;
         node_ff    <= node_in;
         start_ff   <= start_in;
         dist_ff    <= dist_in;
         end_ff     <= end_in;
         err_ff     <= err_in;
         emit_ff    <= emit_in;
         drop_ff    <= drop_in;
      end
   end

endmodule

/* sv/rdpp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpp_queue
// Result word queue: takes up to two records a cycle, hands out one.
// ----------------------------------------------------------------------------
module rdpp_queue
   import rdpp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       pop,
   output record_type out_rec,
   output logic       out_valid,
   output logic       can_accept
);

   record_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic [FIFO_PTR_W-1:0]   wr_ptr_next;

   assign out_valid   = (count_ff != '0);
   assign out_rec     = mem_ff[rd_ptr_ff];
   assign can_accept  = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.num);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push.num) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.num != '0) mem_ff[wr_ptr_ff] <= push.first;
      if (push.num == 2'd2) mem_ff[wr_ptr_next] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue over depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.num != '0) |-> (FIFO_CNT_W'(push.num) + count_ff <= FIFO_CNT_W'(FIFO_DEPTH)))
      else $error("push into full result queue");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push.num == 2'd2) |-> (!push.first.last_result && push.second.last_result
         && push.second.record_kind == KIND_SUMMARY))
      else $error("record pair out of order");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty result queue");
`endif

endmodule

/* sv/rtmp_data_packet_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmp_data_packet_parser_top
// Routing data packet parser: one packet byte in, route and summary words out.
// ----------------------------------------------------------------------------
// The req channel carries one packet byte per word, last_byte set on the final
// byte. The rsp channel returns one word per complete route tuple and one
// summary word after the last byte; last_result marks the final word caused by
// a byte. csr_* writes the type and version registers; the user must write
// them only while the block is idle, which the block itself does not enforce.
// A byte is taken every cycle while ready is high. Its words enter the result
// queue and leave it in order. A last byte that also closes a tuple gives two
// words; the four-word queue keeps ready high while at most two words wait,
// so the sustained rate is one byte per cycle whenever the receiver keeps up.
// When the receiver stalls, words collect in the queue and ready drops once
// three are waiting. Reset empties the queue, clears all packet state and
// loads the registers with type 1 and version 0x82.
// ----------------------------------------------------------------------------
module rtmp_data_packet_parser_top
   import rdpp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   rdpp_req_if.sink          req_if,
   rdpp_rsp_if.source        rsp_if,
   input  logic              csr_write_enable,
   input  csr_index_type     csr_index,
   input  logic [BYTE_W-1:0] csr_write_data
);

   push_type   push;
   record_type out_rec;
   logic       accept;
   logic       pop;
   logic       can_accept;
   logic       out_valid;

   assign req_if.ready = can_accept;
   assign accept       = req_if.valid && can_accept;
   assign pop          = out_valid && rsp_if.ready;

   rdpp_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data_byte        (req_if.data_byte),
      .last_byte        (req_if.last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push             (push)
   );

   rdpp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .out_rec    (out_rec),
      .out_valid  (out_valid),
      .can_accept (can_accept)
   );

   assign rsp_if.valid          = out_valid;
   assign rsp_if.record_kind    = out_rec.record_kind;
   assign rsp_if.start_network  = out_rec.start_network;
   assign rsp_if.net_end        = out_rec.net_end;
   assign rsp_if.hop_distance   = out_rec.hop_distance;
   assign rsp_if.is_extended    = out_rec.is_extended;
   assign rsp_if.sender_net     = out_rec.sender_net;
   assign rsp_if.sender_node    = out_rec.sender_node;
   assign rsp_if.packet_status  = out_rec.packet_status;
   assign rsp_if.tuples_seen    = out_rec.tuples_seen;
   assign rsp_if.tuples_dropped = out_rec.tuples_dropped;
   assign rsp_if.last_result    = out_rec.last_result;

endmodule
